[rtl/rrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types, codes and helpers of the Rice residual decoder.
// ----------------------------------------------------------------------------
package rrd_pkg;

	localparam int SAMPLE_BITS_DEF         = 32;
	localparam int MAX_PARTITION_ORDER_DEF = 15;
	localparam int QUEUE_DEPTH             = 2;

	// Input function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	// Result error codes
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_PARTITION = 2'd2;

	// Classified command handed from front to back
	typedef struct packed {
		logic        is_start;
		logic [15:0] block_size;
		logic [5:0]  predictor_order;
		logic [2:0]  start_bit_offset;
		logic [7:0]  data_byte;
	} cmd_t;

	// Map a folded unsigned value back to a signed residual
	function automatic logic [31:0] zigzag(input logic [32:0] u);
		return u[0] ? ~u[32:1] : u[32:1];
	endfunction

endpackage
`default_nettype wire

[rtl/rrd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_in_if
// Input channel: start items and stream bytes.
// ----------------------------------------------------------------------------
interface rrd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] block_size;
	logic [5:0]  predictor_order;
	logic [2:0]  start_bit_offset;
	logic [7:0]  data_byte;

	modport source (output valid, func, block_size, predictor_order, start_bit_offset,
		data_byte, input ready);
	modport sink (input valid, func, block_size, predictor_order, start_bit_offset,
		data_byte, output ready);
endinterface
`default_nettype wire

[rtl/rrd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_out_if
// Result channel: decoded residuals with run length and status.
// ----------------------------------------------------------------------------
interface rrd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic [15:0]        repeat_count;
	logic               last;
	logic [2:0]         spare_bits;
	logic [1:0]         error;

	modport source (output valid, sample, repeat_count, last, spare_bits, error,
		input ready);
	modport sink (input valid, sample, repeat_count, last, spare_bits, error,
		output ready);
endinterface
`default_nettype wire

[rtl/rice_residual_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rice_residual_decoder
// Partitioned Rice residual decoder with a queued front end and bit-serial core.
// ----------------------------------------------------------------------------
// A start transaction loads the block header fields into the parser. A data byte
// is loaded and then parsed one bit per cycle; the bit-serial parser sets this
// rate, and it stalls while a result waits unread. A two-entry queue in front
// lets new transactions be taken meanwhile.
module rice_residual_decoder #(
	parameter int SAMPLE_BITS         = rrd_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_PARTITION_ORDER = rrd_pkg::MAX_PARTITION_ORDER_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rrd_in_if.sink    items,
	rrd_out_if.source results
);
	import rrd_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	rrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	rrd_back #(
		.SAMPLE_BITS         (SAMPLE_BITS),
		.MAX_PARTITION_ORDER (MAX_PARTITION_ORDER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.results   (results)
	);
endmodule
`default_nettype wire

[rtl/rrd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rrd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rrd_in_if.sink           items,
	output rrd_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  wire logic        cmd_ready
);
	import rrd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [PW:0]       count_q;
	logic              push;
	logic              pop;
	cmd_t              incoming;

	// Classify the incoming transaction
	always_comb begin
		incoming.is_start         = (items.func == FUNC_START);
		incoming.block_size       = items.block_size;
		incoming.predictor_order  = items.predictor_order;
		incoming.start_bit_offset = items.start_bit_offset;
		incoming.data_byte        = items.data_byte;
	end

	assign items.ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready;
	assign cmd_valid   = (count_q != '0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = queue_q[rptr_q];

	// Store payload
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= incoming;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

[rtl/rrd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_back
// Bit-serial parser: walks each byte one bit per cycle unless a result waits unread, and registers results.
// ----------------------------------------------------------------------------
module rrd_back #(
	parameter int SAMPLE_BITS         = rrd_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_PARTITION_ORDER = rrd_pkg::MAX_PARTITION_ORDER_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rrd_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	rrd_out_if.source          results
);
	import rrd_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_METHOD = 3'd1;
	localparam logic [2:0] PH_ORDER  = 3'd2;
	localparam logic [2:0] PH_PARAM  = 3'd3;
	localparam logic [2:0] PH_WIDTH  = 3'd4;
	localparam logic [2:0] PH_UNARY  = 3'd5;
	localparam logic [2:0] PH_LSBS   = 3'd6;
	localparam logic [2:0] PH_RAW    = 3'd7;

	logic [2:0]  phase_q, nxt_phase;
	logic [15:0] blen_q;
	logic [5:0]  warm_q;
	logic        wide_q, nxt_wide;
	logic [3:0]  order_q, nxt_order;
	logic [15:0] pidx_q, nxt_pidx;
	logic [15:0] left_q, nxt_left;
	logic [4:0]  rparam_q, nxt_rparam;
	logic [4:0]  rwidth_q, nxt_rwidth;
	logic [31:0] qcnt_q, nxt_qcnt;
	logic [31:0] acc_q, nxt_acc;
	logic [5:0]  fbits_q, nxt_fbits;
	logic [2:0]  skip_q;
	logic [7:0]  byte_q;
	logic [2:0]  bidx_q;
	logic        active_q;

	logic        res_valid_q;
	logic [31:0] res_sample_q;
	logic [15:0] res_rep_q;
	logic        res_last_q;
	logic [2:0]  res_spare_q;
	logic [1:0]  res_err_q;

	logic        step_en;
	logic        emit;
	logic [31:0] e_sample;
	logic [15:0] e_rep;
	logic        e_last;
	logic [1:0]  e_err;

	logic        b;
	logic [2:0]  spare;
	logic [31:0] acc_sh;
	logic [5:0]  fb_dec;
	logic [4:0]  esc;
	logic [5:0]  hdr_bits;
	logic [15:0] psize_q;
	logic        adv_end;
	logic [3:0]  ord_v;
	logic [15:0] psize0;
	logic [15:0] omask;
	logic [4:0]  rp_v;
	logic [32:0] qinc;
	logic [5:0]  thr_sh;
	logic        q_ovf;
	logic [63:0] u0;
	logic [63:0] u_lsb;
	logic [31:0] wmask;
	logic [31:0] raw_val;
	logic [15:0] lm1;

	assign step_en   = active_q && (!res_valid_q || results.ready);
	assign cmd_ready = !active_q;

	// Shared per-bit terms
	always_comb begin
		b        = byte_q[3'd7 - bidx_q];
		spare    = 3'd7 - bidx_q;
		acc_sh   = {acc_q[30:0], b};
		fb_dec   = (fbits_q != 6'd0) ? fbits_q - 6'd1 : 6'd0;
		esc      = wide_q ? 5'h1F : 5'h0F;
		hdr_bits = wide_q ? 6'd5 : 6'd4;
		psize_q  = blen_q >> order_q;
		adv_end  = (pidx_q == ((16'd1 << order_q) - 16'd1));
		ord_v    = acc_sh[3:0];
		psize0   = blen_q >> ord_v;
		omask    = (16'd1 << ord_v) - 16'd1;
		rp_v     = acc_sh[4:0];
		qinc     = {1'b0, qcnt_q} + 33'd1;
		thr_sh   = 6'(SAMPLE_BITS) - {1'b0, rparam_q};
		q_ovf    = ({1'b0, rparam_q} >= 6'(SAMPLE_BITS)) || ((qinc >> thr_sh) != 33'd0);
		u0       = {32'd0, qcnt_q};
		u_lsb    = (u0 << rparam_q) | {32'd0, acc_sh};
		wmask    = (32'd1 << rwidth_q) - 32'd1;
		raw_val  = acc_sh;
		if (rwidth_q != 5'd0 && acc_sh[rwidth_q - 5'd1]) begin
			raw_val = acc_sh | ~wmask;
		end
		lm1      = left_q - 16'd1;
	end

	// Parse one bit
	always_comb begin
		nxt_phase  = phase_q;
		nxt_wide   = wide_q;
		nxt_order  = order_q;
		nxt_pidx   = pidx_q;
		nxt_left   = left_q;
		nxt_rparam = rparam_q;
		nxt_rwidth = rwidth_q;
		nxt_qcnt   = qcnt_q;
		nxt_acc    = acc_q;
		nxt_fbits  = fbits_q;
		emit       = 1'b0;
		e_sample   = '0;
		e_rep      = '0;
		e_last     = 1'b0;
		e_err      = ERR_OK;

		if (phase_q == PH_UNARY) begin
			if (!b) begin
				if (q_ovf) begin
					nxt_phase = PH_IDLE;
					emit      = 1'b1;
					e_last    = 1'b1;
					e_err     = ERR_OVERFLOW;
				end else begin
					nxt_qcnt = qinc[31:0];
				end
			end else if (rparam_q == 5'd0) begin
				if ((u0 >> SAMPLE_BITS) != 64'd0) begin
					nxt_phase = PH_IDLE;
					emit      = 1'b1;
					e_last    = 1'b1;
					e_err     = ERR_OVERFLOW;
				end else begin
					// Sample done
					emit     = 1'b1;
					e_sample = zigzag(u0[32:0]);
					e_rep    = 16'd1;
					nxt_left = lm1;
					if (lm1 == 16'd0) begin
						if (adv_end) begin
							nxt_phase = PH_IDLE;
							e_last    = 1'b1;
						end else begin
							nxt_pidx  = pidx_q + 16'd1;
							nxt_left  = psize_q;
							nxt_phase = PH_PARAM;
							nxt_acc   = '0;
							nxt_fbits = hdr_bits;
						end
					end else begin
						nxt_phase = PH_UNARY;
						nxt_qcnt  = '0;
					end
				end
			end else begin
				nxt_phase = PH_LSBS;
				nxt_acc   = '0;
				nxt_fbits = {1'b0, rparam_q};
			end
		end else if (phase_q != PH_IDLE) begin
			nxt_acc   = acc_sh;
			nxt_fbits = fb_dec;
			if (fb_dec == 6'd0) begin
				unique case (phase_q)
					PH_METHOD: begin
						nxt_wide  = (acc_sh != 32'd0);
						nxt_phase = PH_ORDER;
						nxt_acc   = '0;
						nxt_fbits = 6'd4;
					end
					PH_ORDER: begin
						nxt_order = ord_v;
						nxt_pidx  = '0;
						if ((ord_v > 4'(MAX_PARTITION_ORDER))
							|| (ord_v == 4'd0 && blen_q < {10'd0, warm_q})
							|| (ord_v != 4'd0 && ((blen_q & omask) != 16'd0
								|| psize0 < {10'd0, warm_q}))) begin
							nxt_phase = PH_IDLE;
							emit      = 1'b1;
							e_last    = 1'b1;
							e_err     = ERR_PARTITION;
						end else begin
							nxt_left  = psize0 - {10'd0, warm_q};
							nxt_phase = PH_PARAM;
							nxt_acc   = '0;
							nxt_fbits = hdr_bits;
						end
					end
					PH_PARAM, PH_WIDTH: begin
						if (phase_q == PH_PARAM) begin
							nxt_rparam = rp_v;
						end else begin
							nxt_rwidth = rp_v;
						end
						if (phase_q == PH_PARAM && rp_v == esc) begin
							nxt_phase = PH_WIDTH;
							nxt_acc   = '0;
							nxt_fbits = 6'd5;
						end else if (left_q == 16'd0) begin
							// Empty partition
							if (adv_end) begin
								nxt_phase = PH_IDLE;
								emit      = 1'b1;
								e_last    = 1'b1;
							end else begin
								nxt_pidx  = pidx_q + 16'd1;
								nxt_left  = psize_q;
								nxt_phase = PH_PARAM;
								nxt_acc   = '0;
								nxt_fbits = hdr_bits;
							end
						end else if (phase_q == PH_WIDTH && rp_v == 5'd0) begin
							// Zero-width run covers the whole partition
							emit     = 1'b1;
							e_rep    = left_q;
							nxt_left = '0;
							if (adv_end) begin
								nxt_phase = PH_IDLE;
								e_last    = 1'b1;
							end else begin
								nxt_pidx  = pidx_q + 16'd1;
								nxt_left  = psize_q;
								nxt_phase = PH_PARAM;
								nxt_acc   = '0;
								nxt_fbits = hdr_bits;
							end
						end else if (phase_q == PH_WIDTH) begin
							nxt_phase = PH_RAW;
							nxt_acc   = '0;
							nxt_fbits = {1'b0, rp_v};
						end else begin
							nxt_phase = PH_UNARY;
							nxt_qcnt  = '0;
						end
					end
					PH_LSBS, PH_RAW: begin
						if (phase_q == PH_LSBS && (u_lsb >> SAMPLE_BITS) != 64'd0) begin
							nxt_phase = PH_IDLE;
							emit      = 1'b1;
							e_last    = 1'b1;
							e_err     = ERR_OVERFLOW;
						end else begin
							emit     = 1'b1;
							e_sample = (phase_q == PH_LSBS) ? zigzag(u_lsb[32:0]) : raw_val;
							e_rep    = 16'd1;
							nxt_left = lm1;
							if (lm1 == 16'd0) begin
								if (adv_end) begin
									nxt_phase = PH_IDLE;
									e_last    = 1'b1;
								end else begin
									nxt_pidx  = pidx_q + 16'd1;
									nxt_left  = psize_q;
									nxt_phase = PH_PARAM;
									nxt_acc   = '0;
									nxt_fbits = hdr_bits;
								end
							end else if (rparam_q == esc) begin
								nxt_phase = PH_RAW;
								nxt_acc   = '0;
								nxt_fbits = {1'b0, rwidth_q};
							end else begin
								nxt_phase = PH_UNARY;
								nxt_qcnt  = '0;
							end
						end
					end
					default: begin
						nxt_phase = phase_q;
					end
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			blen_q   <= '0;
			warm_q   <= '0;
			wide_q   <= 1'b0;
			order_q  <= '0;
			pidx_q   <= '0;
			left_q   <= '0;
			rparam_q <= '0;
			rwidth_q <= '0;
			qcnt_q   <= '0;
			acc_q    <= '0;
			fbits_q  <= '0;
			skip_q   <= '0;
			byte_q   <= '0;
			bidx_q   <= '0;
			active_q <= 1'b0;
		end else if (step_en) begin
			phase_q  <= nxt_phase;
			wide_q   <= nxt_wide;
			order_q  <= nxt_order;
			pidx_q   <= nxt_pidx;
			left_q   <= nxt_left;
			rparam_q <= nxt_rparam;
			rwidth_q <= nxt_rwidth;
			qcnt_q   <= nxt_qcnt;
			acc_q    <= nxt_acc;
			fbits_q  <= nxt_fbits;
			bidx_q   <= bidx_q + 3'd1;
			if (bidx_q == 3'd7 || nxt_phase == PH_IDLE) begin
				active_q <= 1'b0;
			end
		end else if (cmd_valid && cmd_ready) begin
			if (cmd.is_start) begin
				// Load a new block and drop any block in progress
				blen_q   <= cmd.block_size;
				warm_q   <= cmd.predictor_order;
				skip_q   <= cmd.start_bit_offset;
				order_q  <= '0;
				pidx_q   <= '0;
				left_q   <= '0;
				rparam_q <= '0;
				rwidth_q <= '0;
				qcnt_q   <= '0;
				phase_q  <= PH_METHOD;
				acc_q    <= '0;
				fbits_q  <= 6'd2;
			end else if (phase_q != PH_IDLE) begin
				byte_q   <= cmd.data_byte;
				bidx_q   <= skip_q;
				skip_q   <= '0;
				active_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			res_sample_q <= e_sample;
			res_rep_q    <= e_rep;
			res_last_q   <= e_last;
			res_spare_q  <= spare;
			res_err_q    <= e_err;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.sample       = res_sample_q;
	assign results.repeat_count = res_rep_q;
	assign results.last         = res_last_q;
	assign results.spare_bits   = res_spare_q;
	assign results.error        = res_err_q;
endmodule
`default_nettype wire

[rtl/rrd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks on the result channel of the residual decoder.
// ----------------------------------------------------------------------------
module rrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [31:0] sample,
	input wire logic [15:0] repeat_count,
	input wire logic        last,
	input wire logic [1:0]  error
);
	import rrd_pkg::*;

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(sample) && $stable(last))
		else $error("result changed while stalled");

	// Error results close the block and carry no sample
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error != ERR_OK |-> last && repeat_count == 16'd0 && sample == 32'd0)
		else $error("error result is malformed");

	// Only defined error codes
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> error == ERR_OK || error == ERR_OVERFLOW || error == ERR_PARTITION)
		else $error("undefined error code");

	// Results inside a block always count at least one sample
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> repeat_count != 16'd0)
		else $error("empty result before end of block");
endmodule

bind rice_residual_decoder rrd_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (results.valid),
	.ready        (results.ready),
	.sample       (results.sample),
	.repeat_count (results.repeat_count),
	.last         (results.last),
	.error        (results.error)
);
`default_nettype wire
